[sv/bebw_pkg.sv]
package bebw_pkg;

    localparam int LENGTH_BITS_DEF = 32;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       doc_start;
    } in_t;

    typedef struct packed {
        logic [3:0] byte_role;
        logic [7:0] element_type;
        logic       element_last;
        logic       doc_done;
        logic       parse_error;
    } out_t;

    localparam logic [3:0] ROLE_DOC_LEN   = 4'd0;
    localparam logic [3:0] ROLE_TYPE      = 4'd1;
    localparam logic [3:0] ROLE_KEY       = 4'd2;
    localparam logic [3:0] ROLE_KEY_END   = 4'd3;
    localparam logic [3:0] ROLE_LENGTH    = 4'd4;
    localparam logic [3:0] ROLE_VALUE     = 4'd5;
    localparam logic [3:0] ROLE_PATTERN   = 4'd6;
    localparam logic [3:0] ROLE_OPTIONS   = 4'd7;
    localparam logic [3:0] ROLE_DOC_END   = 4'd8;
    localparam logic [3:0] ROLE_IGNORED   = 4'd9;

    localparam logic [7:0] TYPE_END        = 8'h00;
    localparam logic [7:0] TYPE_DOUBLE     = 8'h01;
    localparam logic [7:0] TYPE_STRING     = 8'h02;
    localparam logic [7:0] TYPE_OBJECT     = 8'h03;
    localparam logic [7:0] TYPE_ARRAY      = 8'h04;
    localparam logic [7:0] TYPE_BINARY     = 8'h05;
    localparam logic [7:0] TYPE_OBJECTID   = 8'h07;
    localparam logic [7:0] TYPE_BOOL       = 8'h08;
    localparam logic [7:0] TYPE_DATETIME   = 8'h09;
    localparam logic [7:0] TYPE_NULL       = 8'h0A;
    localparam logic [7:0] TYPE_REGEX      = 8'h0B;
    localparam logic [7:0] TYPE_CODE       = 8'h0D;
    localparam logic [7:0] TYPE_CODE_SCOPE = 8'h0F;
    localparam logic [7:0] TYPE_INT32      = 8'h10;
    localparam logic [7:0] TYPE_TIMESTAMP  = 8'h11;
    localparam logic [7:0] TYPE_INT64      = 8'h12;

    typedef enum logic [2:0] {
        KIND_BAD,
        KIND_FIXED,
        KIND_STR,
        KIND_BIN,
        KIND_TOTAL,
        KIND_REGEX
    } kind_t;

    function automatic kind_t kind_of(input logic [7:0] t);
        kind_t k;
        case (t)
            TYPE_DOUBLE, TYPE_DATETIME, TYPE_TIMESTAMP, TYPE_INT64,
            TYPE_INT32, TYPE_BOOL, TYPE_OBJECTID, TYPE_NULL: k = KIND_FIXED;
            TYPE_STRING, TYPE_CODE:                          k = KIND_STR;
            TYPE_BINARY:                                     k = KIND_BIN;
            TYPE_OBJECT, TYPE_ARRAY, TYPE_CODE_SCOPE:        k = KIND_TOTAL;
            TYPE_REGEX:                                      k = KIND_REGEX;
            default:                                         k = KIND_BAD;
        endcase
        return k;
    endfunction

    function automatic logic [3:0] fixed_size(input logic [7:0] t);
        logic [3:0] n;
        case (t)
            TYPE_DOUBLE, TYPE_DATETIME, TYPE_TIMESTAMP, TYPE_INT64: n = 4'd8;
            TYPE_INT32:    n = 4'd4;
            TYPE_BOOL:     n = 4'd1;
            TYPE_OBJECTID: n = 4'd12;
            default:       n = 4'd0;
        endcase
        return n;
    endfunction

endpackage

[sv/bson_element_boundary_walker_unit.sv]
// Tags each byte of a BSON byte stream with its role (document length, element type, key, length
// field, value, regex strings, document end or ignored) and marks element ends, document end and
// parse errors. One byte is taken per cycle while the output is not stalled, and one tag transaction
// comes out per byte, in order, from the result register; the state of the element
// walk is updated by a single step of logic between the input register and the result register,
// so throughput is one byte per clock unless stalled. LENGTH_BITS bounds accepted declared lengths.
module bson_element_boundary_walker_unit #(
    parameter int LENGTH_BITS = bebw_pkg::LENGTH_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           byte_valid,
    output logic           byte_ready,
    input  bebw_pkg::in_t  byte_item,
    output logic           tag_valid,
    input  logic           tag_ready,
    output bebw_pkg::out_t tag_item
);

    logic           s1_valid_reg;
    bebw_pkg::in_t  s1_item_reg;
    logic           tag_valid_reg;
    bebw_pkg::out_t tag_item_reg;
    bebw_pkg::out_t result;
    logic           step;

    assign step       = s1_valid_reg && (!tag_valid_reg || tag_ready);
    assign byte_ready = !s1_valid_reg || step;
    assign tag_valid  = tag_valid_reg;
    assign tag_item   = tag_item_reg;

    bebw_core #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (s1_item_reg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            tag_valid_reg <= 1'b0;
        end
        else
        begin
            if (byte_ready)
            begin
                s1_valid_reg <= byte_valid;
            end
            if (step)
            begin
                tag_valid_reg <= 1'b1;
            end
            else if (tag_ready)
            begin
                tag_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_ready && byte_valid)
        begin
            s1_item_reg <= byte_item;
        end
        if (step)
        begin
            tag_item_reg <= result;
        end
    end

endmodule

[sv/bebw_core.sv]
module bebw_core #(
    parameter int LENGTH_BITS = bebw_pkg::LENGTH_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step,
    input  bebw_pkg::in_t  item,
    output bebw_pkg::out_t result
);

    localparam int REM_W = LENGTH_BITS + 1;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_DOCLEN,
        PH_TYPE,
        PH_KEY,
        PH_LEN,
        PH_VALUE,
        PH_PATTERN,
        PH_OPTIONS
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [7:0]         type_reg, type_next;
    logic [31:0]        acc_reg, acc_next;
    logic [1:0]         idx_reg, idx_next;
    logic [REM_W-1:0]   rem_reg, rem_next;

    always_comb
    begin
        phase_t            ph;
        logic [7:0]        typ;
        logic [31:0]       acc;
        logic [1:0]        idx;
        logic [REM_W-1:0]  rem;
        logic [7:0]        b;
        logic [31:0]       len;
        logic [REM_W-1:0]  len_r;
        logic              bad;
        bebw_pkg::kind_t   kind;

        b   = item.data_byte;
        ph  = phase_reg;
        typ = type_reg;
        acc = acc_reg;
        idx = idx_reg;
        rem = rem_reg;
        if (item.doc_start)
        begin
            ph  = PH_DOCLEN;
            typ = 8'd0;
            acc = 32'd0;
            idx = 2'd0;
            rem = '0;
        end

        kind  = bebw_pkg::kind_of(typ);
        len   = acc | ({24'd0, b} << {idx, 3'b000});
        len_r = REM_W'(len);
        bad   = len[31] || ((len >> LENGTH_BITS) != 32'd0)
                || ((kind == bebw_pkg::KIND_TOTAL) && (len < 32'd4));

        phase_next = ph;
        type_next  = typ;
        acc_next   = acc;
        idx_next   = idx;
        rem_next   = rem;

        result.byte_role    = bebw_pkg::ROLE_IGNORED;
        result.element_type = 8'd0;
        result.element_last = 1'b0;
        result.doc_done     = 1'b0;
        result.parse_error  = 1'b0;

        case (ph)
            PH_DOCLEN:
            begin
                result.byte_role = bebw_pkg::ROLE_DOC_LEN;
                idx_next = idx + 2'd1;
                if (idx == 2'd3)
                begin
                    phase_next = PH_TYPE;
                end
            end
            PH_TYPE:
            begin
                if (b == bebw_pkg::TYPE_END)
                begin
                    result.byte_role = bebw_pkg::ROLE_DOC_END;
                    result.doc_done  = 1'b1;
                    type_next        = 8'd0;
                    phase_next       = PH_IDLE;
                end
                else if (bebw_pkg::kind_of(b) == bebw_pkg::KIND_BAD)
                begin
                    result.element_type = b;
                    result.parse_error  = 1'b1;
                    type_next           = 8'd0;
                    phase_next          = PH_IDLE;
                end
                else
                begin
                    result.byte_role    = bebw_pkg::ROLE_TYPE;
                    result.element_type = b;
                    type_next           = b;
                    phase_next          = PH_KEY;
                end
            end
            PH_KEY:
            begin
                result.element_type = typ;
                if (b != 8'd0)
                begin
                    result.byte_role = bebw_pkg::ROLE_KEY;
                end
                else
                begin
                    result.byte_role = bebw_pkg::ROLE_KEY_END;
                    case (kind)
                        bebw_pkg::KIND_FIXED:
                        begin
                            if (bebw_pkg::fixed_size(typ) == 4'd0)
                            begin
                                result.element_last = 1'b1;
                                phase_next          = PH_TYPE;
                            end
                            else
                            begin
                                rem_next   = REM_W'(bebw_pkg::fixed_size(typ));
                                phase_next = PH_VALUE;
                            end
                        end
                        bebw_pkg::KIND_REGEX:
                        begin
                            phase_next = PH_PATTERN;
                        end
                        default:
                        begin
                            acc_next   = 32'd0;
                            idx_next   = 2'd0;
                            phase_next = PH_LEN;
                        end
                    endcase
                end
            end
            PH_LEN:
            begin
                result.byte_role    = bebw_pkg::ROLE_LENGTH;
                result.element_type = typ;
                acc_next            = len;
                idx_next            = idx + 2'd1;
                if (idx == 2'd3)
                begin
                    if (bad)
                    begin
                        result.parse_error = 1'b1;
                        phase_next         = PH_IDLE;
                    end
                    else
                    begin
                        case (kind)
                            bebw_pkg::KIND_BIN:   rem_next = len_r + REM_W'(1);
                            bebw_pkg::KIND_TOTAL: rem_next = len_r - REM_W'(4);
                            default:              rem_next = len_r;
                        endcase
                        if (rem_next == '0)
                        begin
                            result.element_last = 1'b1;
                            phase_next          = PH_TYPE;
                        end
                        else
                        begin
                            phase_next = PH_VALUE;
                        end
                    end
                end
            end
            PH_VALUE:
            begin
                result.byte_role    = bebw_pkg::ROLE_VALUE;
                result.element_type = typ;
                if (rem <= REM_W'(1))
                begin
                    rem_next            = '0;
                    result.element_last = 1'b1;
                    phase_next          = PH_TYPE;
                end
                else
                begin
                    rem_next = rem - REM_W'(1);
                end
            end
            PH_PATTERN:
            begin
                result.byte_role    = bebw_pkg::ROLE_PATTERN;
                result.element_type = typ;
                if (b == 8'd0)
                begin
                    phase_next = PH_OPTIONS;
                end
            end
            PH_OPTIONS:
            begin
                result.byte_role    = bebw_pkg::ROLE_OPTIONS;
                result.element_type = typ;
                if (b == 8'd0)
                begin
                    result.element_last = 1'b1;
                    phase_next          = PH_TYPE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            type_reg  <= 8'd0;
            acc_reg   <= 32'd0;
            idx_reg   <= 2'd0;
            rem_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            type_reg  <= type_next;
            acc_reg   <= acc_next;
            idx_reg   <= idx_next;
            rem_reg   <= rem_next;
        end
    end

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        step && result.doc_done |=> phase_reg == PH_IDLE)
        else $error("phase not idle after document end");

    a_err_idle: assert property (@(posedge clk) disable iff (!rst_n)
        step && result.parse_error |=> phase_reg == PH_IDLE)
        else $error("phase not idle after parse error");

    a_last_type: assert property (@(posedge clk) disable iff (!rst_n)
        step && result.element_last |=> phase_reg == PH_TYPE)
        else $error("element end not followed by type byte");

    a_value_rem: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_VALUE |-> rem_reg != '0)
        else $error("value phase with no bytes remaining");

endmodule

[bench/bson_tag_checker.sv]
`timescale 1ns / 1ps
module bson_tag_checker
    import bebw_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic byte_valid,
    input  logic byte_ready,
    input  in_t  byte_item,
    input  logic tag_valid,
    input  logic tag_ready,
    input  out_t tag_item,
    output int   mismatches,
    output int   tags_outstanding
);

    typedef enum logic [2:0] {
        WALK_IDLE,
        WALK_DOC_LEN,
        WALK_TYPE,
        WALK_KEY,
        WALK_LEN,
        WALK_VALUE,
        WALK_PATTERN,
        WALK_OPTIONS
    } walk_phase_t;

    walk_phase_t walk_phase = WALK_IDLE;
    logic [7:0]  cur_type = '0;
    logic [31:0] len_acc = '0;
    logic [1:0]  len_idx = '0;
    logic [32:0] remaining = '0;

    out_t expected_tags[$];
    out_t want;
    int   mismatch_count = 0;
    int   outstanding = 0;
    int   tags_checked = 0;

    assign mismatches = mismatch_count;
    assign tags_outstanding = outstanding;

    function automatic kind_t value_class(input logic [7:0] t, output logic [32:0] vsize);
        vsize = '0;
        case (t)
            TYPE_DOUBLE, TYPE_DATETIME, TYPE_TIMESTAMP, TYPE_INT64:
            begin
                vsize = 33'd8;
                return KIND_FIXED;
            end
            TYPE_INT32:
            begin
                vsize = 33'd4;
                return KIND_FIXED;
            end
            TYPE_BOOL:
            begin
                vsize = 33'd1;
                return KIND_FIXED;
            end
            TYPE_OBJECTID:
            begin
                vsize = 33'd12;
                return KIND_FIXED;
            end
            TYPE_NULL:                                return KIND_FIXED;
            TYPE_STRING, TYPE_CODE:                   return KIND_STR;
            TYPE_BINARY:                              return KIND_BIN;
            TYPE_OBJECT, TYPE_ARRAY, TYPE_CODE_SCOPE: return KIND_TOTAL;
            TYPE_REGEX:                               return KIND_REGEX;
            default:                                  return KIND_BAD;
        endcase
    endfunction

    function automatic out_t walk_byte(input in_t x);
        out_t        o;
        kind_t       k;
        logic [32:0] vsize;
        logic [63:0] len;
        logic        bad;
        o = '0;
        o.byte_role = ROLE_IGNORED;
        if (x.doc_start)
        begin
            walk_phase = WALK_DOC_LEN;
            cur_type = '0;
            len_acc = '0;
            len_idx = '0;
            remaining = '0;
        end
        case (walk_phase)
            WALK_DOC_LEN:
            begin
                o.byte_role = ROLE_DOC_LEN;
                if (len_idx == 2'd3)
                    walk_phase = WALK_TYPE;
                len_idx = len_idx + 2'd1;
            end
            WALK_TYPE:
            begin
                if (x.data_byte == TYPE_END)
                begin
                    o.byte_role = ROLE_DOC_END;
                    o.doc_done = 1'b1;
                    cur_type = '0;
                    walk_phase = WALK_IDLE;
                end
                else if (value_class(x.data_byte, vsize) == KIND_BAD)
                begin
                    o.element_type = x.data_byte;
                    o.parse_error = 1'b1;
                    cur_type = '0;
                    walk_phase = WALK_IDLE;
                end
                else
                begin
                    o.byte_role = ROLE_TYPE;
                    o.element_type = x.data_byte;
                    cur_type = x.data_byte;
                    walk_phase = WALK_KEY;
                end
            end
            WALK_KEY:
            begin
                o.element_type = cur_type;
                if (x.data_byte != 8'd0)
                    o.byte_role = ROLE_KEY;
                else
                begin
                    o.byte_role = ROLE_KEY_END;
                    k = value_class(cur_type, vsize);
                    if (k == KIND_FIXED)
                    begin
                        if (vsize == '0)
                        begin
                            o.element_last = 1'b1;
                            walk_phase = WALK_TYPE;
                        end
                        else
                        begin
                            remaining = vsize;
                            walk_phase = WALK_VALUE;
                        end
                    end
                    else if (k == KIND_REGEX)
                        walk_phase = WALK_PATTERN;
                    else
                    begin
                        len_acc = '0;
                        len_idx = '0;
                        walk_phase = WALK_LEN;
                    end
                end
            end
            WALK_LEN:
            begin
                o.byte_role = ROLE_LENGTH;
                o.element_type = cur_type;
                len_acc = len_acc | (32'(x.data_byte) << (8 * len_idx));
                if (len_idx != 2'd3)
                    len_idx = len_idx + 2'd1;
                else
                begin
                    len_idx = '0;
                    k = value_class(cur_type, vsize);
                    len = {32'd0, len_acc};
                    bad = len_acc[31] || ((len >> LENGTH_BITS) != 64'd0);
                    if (k == KIND_TOTAL && len_acc < 32'd4)
                        bad = 1'b1;
                    if (bad)
                    begin
                        o.parse_error = 1'b1;
                        walk_phase = WALK_IDLE;
                    end
                    else
                    begin
                        if (k == KIND_BIN)
                            remaining = {1'b0, len_acc} + 33'd1;
                        else if (k == KIND_TOTAL)
                            remaining = {1'b0, len_acc} - 33'd4;
                        else
                            remaining = {1'b0, len_acc};
                        if (remaining == '0)
                        begin
                            o.element_last = 1'b1;
                            walk_phase = WALK_TYPE;
                        end
                        else
                            walk_phase = WALK_VALUE;
                    end
                end
            end
            WALK_VALUE:
            begin
                o.byte_role = ROLE_VALUE;
                o.element_type = cur_type;
                if (remaining <= 33'd1)
                begin
                    remaining = '0;
                    o.element_last = 1'b1;
                    walk_phase = WALK_TYPE;
                end
                else
                    remaining = remaining - 33'd1;
            end
            WALK_PATTERN:
            begin
                o.byte_role = ROLE_PATTERN;
                o.element_type = cur_type;
                if (x.data_byte == 8'd0)
                    walk_phase = WALK_OPTIONS;
            end
            WALK_OPTIONS:
            begin
                o.byte_role = ROLE_OPTIONS;
                o.element_type = cur_type;
                if (x.data_byte == 8'd0)
                begin
                    o.element_last = 1'b1;
                    walk_phase = WALK_TYPE;
                end
            end
            default:
                walk_phase = WALK_IDLE;
        endcase
        return o;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned exp_val);
        if (mismatch_count < 40)
            $display("%0t: tag %0d: %s mismatch, got %0d expected %0d",
                     $time, tags_checked, what, got, exp_val);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            walk_phase = WALK_IDLE;
            cur_type = '0;
            len_acc = '0;
            len_idx = '0;
            remaining = '0;
            expected_tags.delete();
        end
        else
        begin
            if (byte_valid && byte_ready)
                expected_tags.insert(expected_tags.size(), walk_byte(byte_item));
            if (tag_valid && tag_ready)
            begin
                if (expected_tags.size() == 0)
                    report_mismatch("unexpected transaction", 32'(tag_item), 32'd0);
                else
                begin
                    want = expected_tags.pop_front();
                    if (tag_item.byte_role != want.byte_role)
                        report_mismatch("byte_role", 32'(tag_item.byte_role),
                                        32'(want.byte_role));
                    if (tag_item.element_type != want.element_type)
                        report_mismatch("element_type", 32'(tag_item.element_type),
                                        32'(want.element_type));
                    if (tag_item.element_last != want.element_last)
                        report_mismatch("element_last", 32'(tag_item.element_last),
                                        32'(want.element_last));
                    if (tag_item.doc_done != want.doc_done)
                        report_mismatch("doc_done", 32'(tag_item.doc_done),
                                        32'(want.doc_done));
                    if (tag_item.parse_error != want.parse_error)
                        report_mismatch("parse_error", 32'(tag_item.parse_error),
                                        32'(want.parse_error));
                end
                tags_checked++;
            end
        end
        outstanding = expected_tags.size();
    end

endmodule

[bench/bson_element_boundary_walker_unit_test.sv]
`timescale 1ns / 1ps
module bson_element_boundary_walker_unit_test;

    import bebw_pkg::*;

    localparam logic [7:0] TYPE_UNDEFINED  = 8'h06;
    localparam logic [7:0] TYPE_DBPOINTER  = 8'h0C;
    localparam logic [7:0] TYPE_SYMBOL     = 8'h0E;
    localparam logic [7:0] TYPE_DECIMAL128 = 8'h13;
    localparam logic [7:0] TYPE_MAX_KEY    = 8'h7F;
    localparam logic [7:0] TYPE_MIN_KEY    = 8'hFF;

    localparam logic [7:0] KNOWN_TYPES [15] = '{
        TYPE_DOUBLE, TYPE_STRING, TYPE_OBJECT, TYPE_ARRAY, TYPE_BINARY,
        TYPE_OBJECTID, TYPE_BOOL, TYPE_DATETIME, TYPE_NULL, TYPE_REGEX,
        TYPE_CODE, TYPE_CODE_SCOPE, TYPE_INT32, TYPE_TIMESTAMP, TYPE_INT64
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic byte_valid = 1'b0;
    logic byte_ready;
    in_t  byte_item = '0;
    logic tag_valid;
    logic tag_ready = 1'b0;
    out_t tag_item;

    int   mismatches;
    int   tags_outstanding;
    int   send_idle_pct = 0;
    int   stall_pct = 0;
    int   bytes_sent = 0;
    logic pressure_go = 1'b0;
    int   hold_count = 0;

    bson_element_boundary_walker_unit i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_item  (byte_item),
        .tag_valid  (tag_valid),
        .tag_ready  (tag_ready),
        .tag_item   (tag_item)
    );

    bson_tag_checker i_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .byte_valid       (byte_valid),
        .byte_ready       (byte_ready),
        .byte_item        (byte_item),
        .tag_valid        (tag_valid),
        .tag_ready        (tag_ready),
        .tag_item         (tag_item),
        .mismatches       (mismatches),
        .tags_outstanding (tags_outstanding)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // long hold-off so the block fills up and stalls its input
    always @(negedge clk)
    begin
        if (pressure_go && hold_count < 400)
        begin
            tag_ready = 1'b0;
            hold_count++;
        end
        else
            tag_ready = ($urandom_range(99) >= stall_pct);
    end

    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b, input logic s);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            byte_valid = 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        byte_item.data_byte = b;
        byte_item.doc_start = s;
        byte_valid = 1'b1;
        do
            @(posedge clk);
        while (!byte_ready);
        @(negedge clk);
        bytes_sent++;
    endtask

    task automatic send_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++)
            send_byte(w[8*i +: 8], 1'b0);
    endtask

    task automatic send_cstring(input int n);
        repeat (n)
            send_byte(8'($urandom_range(1, 255)), 1'b0);
        send_byte(8'd0, 1'b0);
    endtask

    task automatic open_doc();
        send_byte(8'($urandom_range(0, 255)), 1'b1);
        repeat (3)
            send_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    function automatic logic [31:0] pick_length(input bit self_incl);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 4)
            return {1'b1, 31'($urandom)};
        if (self_incl && r < 10)
            return 32'($urandom_range(0, 3));
        if (r < 12)
            return 32'($urandom_range(100, 300)) + (self_incl ? 32'd4 : 32'd0);
        return 32'($urandom_range(0, 10)) + (self_incl ? 32'd4 : 32'd0);
    endfunction

    function automatic logic [7:0] pick_type();
        int unsigned r;
        r = $urandom_range(99);
        if (r >= 8)
            return KNOWN_TYPES[$urandom_range(0, 14)];
        case (r % 4)
            0:       return TYPE_UNDEFINED;
            1:       return (r < 4) ? TYPE_DBPOINTER : TYPE_SYMBOL;
            2:       return (r < 4) ? TYPE_MAX_KEY : TYPE_MIN_KEY;
            default: return 8'($urandom_range(TYPE_DECIMAL128, 8'hFF));
        endcase
    endfunction

    task automatic send_element(input logic [7:0] t, output bit broke);
        logic [31:0] len;
        broke = 1'b0;
        send_byte(t, 1'b0);
        case (t)
            TYPE_DOUBLE, TYPE_STRING, TYPE_OBJECT, TYPE_ARRAY, TYPE_BINARY,
            TYPE_OBJECTID, TYPE_BOOL, TYPE_DATETIME, TYPE_NULL, TYPE_REGEX,
            TYPE_CODE, TYPE_CODE_SCOPE, TYPE_INT32, TYPE_TIMESTAMP, TYPE_INT64:
                send_cstring($urandom_range(0, 3));
            default:
            begin
                broke = 1'b1;
                return;
            end
        endcase
        case (t)
            TYPE_DOUBLE, TYPE_DATETIME, TYPE_TIMESTAMP, TYPE_INT64:
                repeat (8) send_byte(8'($urandom_range(0, 255)), 1'b0);
            TYPE_INT32:
                repeat (4) send_byte(8'($urandom_range(0, 255)), 1'b0);
            TYPE_BOOL:
                send_byte(8'($urandom_range(0, 1)), 1'b0);
            TYPE_OBJECTID:
                repeat (12) send_byte(8'($urandom_range(0, 255)), 1'b0);
            TYPE_STRING, TYPE_CODE, TYPE_BINARY:
            begin
                len = pick_length(1'b0);
                send_word(len);
                if (len[31])
                    broke = 1'b1;
                else
                    repeat (int'(len) + ((t == TYPE_BINARY) ? 1 : 0))
                        send_byte(8'($urandom_range(0, 255)), 1'b0);
            end
            TYPE_OBJECT, TYPE_ARRAY, TYPE_CODE_SCOPE:
            begin
                len = pick_length(1'b1);
                send_word(len);
                if (len[31] || len < 32'd4)
                    broke = 1'b1;
                else
                    repeat (int'(len) - 4)
                        send_byte(8'($urandom_range(0, 255)), 1'b0);
            end
            TYPE_REGEX:
            begin
                send_cstring($urandom_range(0, 4));
                send_cstring($urandom_range(0, 3));
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic random_doc();
        int n;
        bit broke;
        broke = 1'b0;
        open_doc();
        n = $urandom_range(0, 5);
        for (int i = 0; i < n && !broke; i++)
        begin
            // cut the document short inside an element, the next doc_start restarts it
            if ($urandom_range(99) < 5)
            begin
                send_byte(KNOWN_TYPES[$urandom_range(0, 14)], 1'b0);
                send_cstring($urandom_range(0, 1));
                repeat ($urandom_range(0, 3))
                    send_byte(8'($urandom_range(0, 255)), 1'b0);
                return;
            end
            send_element(pick_type(), broke);
        end
        if (!broke && $urandom_range(99) < 90)
            send_byte(TYPE_END, 1'b0);
        if ($urandom_range(99) < 25)
            repeat ($urandom_range(1, 4))
                send_byte(8'($urandom_range(0, 255)), ($urandom_range(99) < 5));
    endtask

    initial
    begin
        int target;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // bytes before any document
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        // null and empty string values, then an unknown type
        send_byte(8'h0C, 1'b1);
        repeat (3) send_byte(8'h00, 1'b0);
        send_byte(TYPE_NULL, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(TYPE_STRING, 1'b0);
        send_byte(8'h00, 1'b0);
        send_word(32'd0);
        send_byte(TYPE_MIN_KEY, 1'b0);
        send_byte(8'h55, 1'b0);
        // empty embedded object, then document end
        send_byte(8'hFF, 1'b1);
        repeat (3) send_byte(8'hFF, 1'b0);
        send_byte(TYPE_OBJECT, 1'b0);
        send_byte(8'h00, 1'b0);
        send_word(32'd4);
        send_byte(TYPE_END, 1'b0);

        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct = (p == 1) ? 80 : (p == 3) ? 31 : 0;
            stall_pct = (p == 2) ? 80 : (p == 3) ? 31 : 0;
            target = bytes_sent + 330;
            while (bytes_sent < target)
            begin
                if (p == 0 && bytes_sent > 80)
                    pressure_go = 1'b1;
                random_doc();
            end
        end
        byte_valid = 1'b0;

        while (tags_outstanding != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0 && tags_outstanding == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
